// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/ssdw_pkg.sv -----
// package for the signed decimal seven-segment writer
// types, constants and the segment table; no dependencies
package ssdw_pkg;

    localparam int VALUE_W            = 32;
    localparam int ADDR_W             = 4;
    localparam int SEG_W              = 8;
    localparam int BCD_DIGITS         = 10;
    localparam int BCD_W              = 4 * BCD_DIGITS;
    localparam int DIGIT_CNT_W        = 4;
    localparam int DISPLAY_DIGITS_DEF = 8;

    localparam logic [SEG_W-1:0] PATTERN_ZERO  = 8'h7E;
    localparam logic [SEG_W-1:0] PATTERN_MINUS = 8'h01;
    localparam logic [SEG_W-1:0] PATTERN_BLANK = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CLEAR,
        ST_MINUS,
        ST_DIGIT
    } wr_state_t;

    typedef struct packed {
        logic                   done;
        logic [DIGIT_CNT_W-1:0] digit_count;
    } conv_status_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h7E;
            4'd1:    pat = 8'h30;
            4'd2:    pat = 8'h6D;
            4'd3:    pat = 8'h79;
            4'd4:    pat = 8'h33;
            4'd5:    pat = 8'h5B;
            4'd6:    pat = 8'h5F;
            4'd7:    pat = 8'h70;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h7B;
            default: pat = PATTERN_BLANK;
        endcase
        return pat;
    endfunction

endpackage

// ----- hw/rtl/ssdw_value_if.sv -----
// valid/ready channel carrying one signed input value per item
// depends on ssdw_pkg
interface ssdw_value_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ssdw_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- hw/rtl/ssdw_write_if.sv -----
// valid/ready channel carrying one display register write per item
// depends on ssdw_pkg
interface ssdw_write_if;
    logic                          valid;
    logic                          ready;
    logic [ssdw_pkg::ADDR_W-1:0]   reg_address;
    logic [ssdw_pkg::SEG_W-1:0]    seg_data;
    logic                          last;

    modport source (output valid, output reg_address, output seg_data, output last,
                    input ready);
    modport sink   (input valid, input reg_address, input seg_data, input last,
                    output ready);
endinterface

// ----- hw/rtl/ssdw_bcd_conv.sv -----
// bit-serial binary to bcd converter, one input bit per cycle (shift and add-3)
// depends on ssdw_pkg
module ssdw_bcd_conv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ssdw_pkg::VALUE_W-1:0]    mag,
    output ssdw_pkg::conv_status_t          status,
    output logic [ssdw_pkg::BCD_W-1:0]      bcd
);
    import ssdw_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [DIGIT_CNT_W-1:0] digit_count;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = mag;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // highest nonzero digit sets the digit count
    always_comb
    begin
        digit_count = '0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
                digit_count = DIGIT_CNT_W'(i + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.done        = done_reg;
    assign status.digit_count = digit_count;
    assign bcd                = bcd_reg;

endmodule

// ----- hw/rtl/signed_decimal_seg7_writer.sv -----
// signed decimal to seven-segment display writer, top level
// depends on ssdw_pkg, ssdw_value_if, ssdw_write_if, ssdw_bcd_conv
//
//   port   dir     handshake     payload
//   cmd    sink    valid/ready   value (signed 32)
//   wr     source  valid/ready   reg_address (4), seg_data (8), last (1)
//
// one item is taken while idle; the serial bcd converter then takes its magnitude
// one input bit at a time, and the digits are captured when it reports done
// writes follow at one per cycle while wr is ready: DISPLAY_DIGITS zero-pattern
// writes, an optional minus, then up to DISPLAY_DIGITS digits
// a stalled wr channel holds the current write and pauses the run
// reset clears control state only; there is no clearing pass
module signed_decimal_seg7_writer #(
    parameter int DISPLAY_DIGITS = ssdw_pkg::DISPLAY_DIGITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ssdw_value_if.sink    cmd,
    ssdw_write_if.source  wr
);
    import ssdw_pkg::*;

    localparam logic [ADDR_W-1:0] TOP_POS = ADDR_W'(DISPLAY_DIGITS);

    wr_state_t              state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [SEG_W-1:0]       data_reg, data_next;
    logic                   last_reg, last_next;
    logic                   neg_reg, neg_next;
    logic [BCD_W-1:0]       dig_reg, dig_next;
    logic [DIGIT_CNT_W-1:0] digs_reg, digs_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;

    logic                   accept;
    logic                   slot_free;
    logic                   zero_val;
    logic                   minus_ok;
    logic [ADDR_W-1:0]      dig_lim;
    logic [VALUE_W-1:0]     raw;
    logic [VALUE_W-1:0]     mag;
    conv_status_t           conv_status;
    logic [BCD_W-1:0]       conv_bcd;

    assign accept    = cmd.valid && cmd.ready;
    assign slot_free = !out_valid_reg || wr.ready;
    assign raw       = cmd.value;
    assign mag       = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    assign zero_val  = (digs_reg == '0);
    assign minus_ok  = neg_reg && (ADDR_W'(digs_reg) < TOP_POS);
    assign dig_lim   = (ADDR_W'(digs_reg) < TOP_POS) ? ADDR_W'(digs_reg) : TOP_POS;

    ssdw_bcd_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mag    (mag),
        .status (conv_status),
        .bcd    (conv_bcd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_CONV;
            ST_CONV:
                if (conv_status.done)
                    state_next = ST_CLEAR;
            ST_CLEAR:
                if (slot_free && (pos_reg == ADDR_W'(1)))
                begin
                    if (zero_val)
                        state_next = ST_IDLE;
                    else if (minus_ok)
                        state_next = ST_MINUS;
                    else
                        state_next = ST_DIGIT;
                end
            ST_MINUS:
                if (slot_free)
                    state_next = ST_DIGIT;
            ST_DIGIT:
                if (slot_free && (pos_reg == dig_lim))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !wr.ready;
        addr_next      = addr_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        neg_next       = neg_reg;
        dig_next       = dig_reg;
        digs_next      = digs_reg;
        pos_next       = pos_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    neg_next = raw[VALUE_W-1];
            ST_CONV:
                if (conv_status.done)
                begin
                    dig_next  = conv_bcd;
                    digs_next = conv_status.digit_count;
                    pos_next  = TOP_POS;
                end
            ST_CLEAR:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = pos_reg;
                    data_next      = PATTERN_ZERO;
                    last_next      = (pos_reg == ADDR_W'(1)) && zero_val;
                    if (pos_reg != ADDR_W'(1))
                        pos_next = pos_reg - 1'b1;
                end
            ST_MINUS:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = ADDR_W'(digs_reg) + 1'b1;
                    data_next      = PATTERN_MINUS;
                    last_next      = 1'b0;
                end
            ST_DIGIT:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    addr_next      = pos_reg;
                    data_next      = seg_pattern(dig_reg[3:0]);
                    last_next      = (pos_reg == dig_lim);
                    dig_next       = {4'd0, dig_reg[BCD_W-1:4]};
                    pos_next       = pos_reg + 1'b1;
                end
            default:
            begin
                out_valid_next = out_valid_reg && !wr.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        data_reg <= data_next;
        last_reg <= last_next;
        neg_reg  <= neg_next;
        dig_reg  <= dig_next;
        digs_reg <= digs_next;
        pos_reg  <= pos_next;
    end

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign wr.valid       = out_valid_reg;
    assign wr.reg_address = addr_reg;
    assign wr.seg_data    = data_reg;
    assign wr.last        = last_reg;

endmodule

// ----- hw/rtl/ssdw_checker.sv -----
// port-level assertions for the seven-segment writer, bound to the top level
// depends on ssdw_pkg, assert_macros.svh, signed_decimal_seg7_writer
`include "assert_macros.svh"

module ssdw_checker #(
    parameter int DISPLAY_DIGITS = ssdw_pkg::DISPLAY_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_ready,
    input  logic                          wr_valid,
    input  logic                          wr_ready,
    input  logic [ssdw_pkg::ADDR_W-1:0]   wr_reg_address,
    input  logic [ssdw_pkg::SEG_W-1:0]    wr_seg_data,
    input  logic                          wr_last
);
    import ssdw_pkg::*;

    // writes only target digit positions on the display
    `ASSERT_IMPLIES(a_addr_range, clk, rst_n, wr_valid, (wr_reg_address >= ADDR_W'(1)) && (wr_reg_address <= ADDR_W'(DISPLAY_DIGITS)))

    // one item at a time: busy right after an accepted item
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // a minus write is always followed by at least one digit
    `ASSERT_IMPLIES(a_minus_not_last, clk, rst_n, wr_valid && (wr_seg_data == PATTERN_MINUS), !wr_last)

    // stalled write holds
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, wr_valid && !wr_ready, wr_valid && $stable(wr_reg_address) && $stable(wr_seg_data) && $stable(wr_last))

endmodule

bind signed_decimal_seg7_writer ssdw_checker #(
    .DISPLAY_DIGITS (DISPLAY_DIGITS)
) u_ssdw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .wr_valid       (wr.valid),
    .wr_ready       (wr.ready),
    .wr_reg_address (wr.reg_address),
    .wr_seg_data    (wr.seg_data),
    .wr_last        (wr.last)
);

// ----- tb/tb_signed_decimal_seg7_writer.sv -----
// self-checking testbench for signed_decimal_seg7_writer: signed values in, display writes out
// predicts every write run per value, checks it in order under four sender/receiver idling mixes
// depends on ssdw_pkg, ssdw_value_if, ssdw_write_if and the writer rtl
module tb_signed_decimal_seg7_writer;

    import ssdw_pkg::*;

    localparam int NUM_POSITIONS = DISPLAY_DIGITS_DEF;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 80;

    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SEG_W-1:0]  seg;
        logic              last;
        int                src_value;
    } disp_write_t;

    class display_write_tracker;
        disp_write_t pending_writes [$];
        int          mismatches;
        int          values_noted;
        int          writes_checked;

        // predicts the write run of one accepted value
        function void note_value(logic signed [VALUE_W-1:0] v);
            disp_write_t      run [$];
            disp_write_t      w;
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] rest;
            int               digs;
            w.last      = 1'b0;
            w.src_value = v;
            for (int pos = NUM_POSITIONS; pos >= 1; pos--)
            begin
                w.addr = ADDR_W'(pos);
                w.seg  = PATTERN_ZERO;
                run.push_back(w);
            end
            mag = v[VALUE_W-1] ? (32'd0 - v) : v;
            if (mag != 0)
            begin
                digs = 0;
                rest = mag;
                while (rest != 0)
                begin
                    rest = rest / 10;
                    digs++;
                end
                if (v[VALUE_W-1] && digs + 1 <= NUM_POSITIONS)
                begin
                    w.addr = ADDR_W'(digs + 1);
                    w.seg  = PATTERN_MINUS;
                    run.push_back(w);
                end
                for (int k = 0; k < digs; k++)
                begin
                    if (k + 1 <= NUM_POSITIONS)
                    begin
                        w.addr = ADDR_W'(k + 1);
                        w.seg  = DIGIT_SEGS[mag % 10];
                        run.push_back(w);
                    end
                    mag = mag / 10;
                end
            end
            w = run.pop_back();
            w.last = 1'b1;
            run.push_back(w);
            foreach (run[i])
                pending_writes.push_back(run[i]);
            values_noted++;
        endfunction

        function void check_write(logic [ADDR_W-1:0] a, logic [SEG_W-1:0] s, logic l);
            disp_write_t e;
            writes_checked++;
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected write: addr %0d seg %02h last %0b", a, s, l);
                return;
            end
            e = pending_writes.pop_front();
            if (a !== e.addr || s !== e.seg || l !== e.last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("write mismatch for value %0d: expected addr %0d seg %02h last %0b, got addr %0d seg %02h last %0b",
                             e.src_value, e.addr, e.seg, e.last, a, s, l);
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;

    display_write_tracker sb = new();

    ssdw_value_if cmd_if();
    ssdw_write_if wr_if();

    signed_decimal_seg7_writer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .wr    (wr_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // output side: check accepted writes, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && wr_if.valid && wr_if.ready)
            sb.check_write(wr_if.reg_address, wr_if.seg_data, wr_if.last);
        wr_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("signed_decimal_seg7_writer verification failed");
        $finish;
    end

    // called right after a rising edge; returns on the edge that accepts the item
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.value <= v;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_value(v);
    endtask

    task automatic drain_writes();
        cmd_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        longint unsigned    p;
        longint unsigned    m;
        int                 d;
        bit                 neg;
        logic signed [VALUE_W-1:0] v;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count)
        begin
            neg = $urandom_range(1);
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    // random digit count, random digits
                    d = $urandom_range(1, 10);
                    p = 1;
                    repeat (d) p = p * 10;
                    m = {$urandom, $urandom} % p;
                end
                4, 5:
                begin
                    m = $urandom;
                    neg = m[31];
                    m = neg ? (64'h1_0000_0000 - m) : m;
                end
                6:
                begin
                    // around a power of ten
                    d = $urandom_range(0, 9);
                    p = 1;
                    repeat (d) p = p * 10;
                    m = p - $urandom_range(1);
                end
                7:
                begin
                    case ($urandom_range(3))
                        0: m = 64'h7FFF_FFFF;
                        1: m = 64'h8000_0000;
                        2: m = 64'h7FFF_FFFE;
                        default: m = 0;
                    endcase
                end
                default: m = $urandom_range(99);
            endcase
            if (neg)
            begin
                if (m > 64'h8000_0000)
                    m = 64'h8000_0000;
                v = 32'd0 - m[31:0];
            end
            else
            begin
                if (m > 64'h7FFF_FFFF)
                    m = 64'h7FFF_FFFF;
                v = m[31:0];
            end
            send_value(v);
        end
    endtask

    initial
    begin
        int directed_values [22] = '{
            0, 1, -1, 9, -9, 10, -10, -100, 4096,
            2147483647, int'(32'h8000_0000), -2147483647,
            99999999, -99999999, -9999999, 12345678, -12345678,
            123456789, -123456789, 1000000000, 1234567890, -1234567890
        };
        cmd_if.valid = 1'b0;
        cmd_if.value = '0;
        wr_if.ready  = 1'b0;
        rst_n        = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_values[i])
            send_value(directed_values[i]);
        drain_writes();

        run_phase(0, 0, 115);
        run_phase(81, 0, 115);
        drain_writes();
        run_phase(0, 81, 115);
        run_phase(6, 6, 115);
        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d signed values (directed extremes plus random digit counts)",
                 sb.values_noted);
        $display("%0d display writes checked under four idle/stall mixes, %0d mismatches",
                 sb.writes_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("signed_decimal_seg7_writer verification clean");
        else
            $display("signed_decimal_seg7_writer verification failed");
        $finish;
    end

endmodule
